>>> rtl/core/even_count_median_filter_macros.svh
// assertion macros for the even count median filter
`ifndef EVEN_COUNT_MEDIAN_FILTER_MACROS_SVH
`define EVEN_COUNT_MEDIAN_FILTER_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, checked out of reset
`define ECMF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ecmf assertion failed");
// next-cycle implication, checked out of reset
`define ECMF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ecmf assertion failed");
`else
`define ECMF_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define ECMF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/core/ecmf_pkg.sv
// shared constants and types for the even count median filter
`default_nettype none

package ecmf_pkg;

    localparam int SAMPLE_W        = 24;
    localparam int STATUS_W        = 2;
    localparam int CFG_W           = 8;
    localparam int MAX_SAMPLES_DEF = 16;

    localparam logic [CFG_W-1:0] CFG_RESET = 8'd16;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_COUNT = 2'd1,
        ST_TIMEOUT   = 2'd2
    } t_status;

endpackage

`default_nettype wire

>>> rtl/core/ecmf_if.sv
// valid/ready channel interfaces for sample and result beats
`default_nettype none

interface ecmf_smp_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [ecmf_pkg::SAMPLE_W-1:0]  sample;
    logic                                  timed_out;

    modport source (output valid, output sample, output timed_out, input ready);
    modport sink   (input valid, input sample, input timed_out, output ready);
endinterface

interface ecmf_res_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [ecmf_pkg::SAMPLE_W-1:0]  median;
    logic        [ecmf_pkg::STATUS_W-1:0]  status;

    modport source (output valid, output median, output status, input ready);
    modport sink   (input valid, input median, input status, output ready);
endinterface

`default_nettype wire

>>> rtl/core/even_count_median_filter.sv
// per stored sample: accept in idle, scan down the store shifting larger entries up one place,
//   write the sample (in scan or place), check the count; at batch end read both middles, emit
// error beats (bad count, timeout) go via emit to the output register, which waits for ready
// scan speed is set by the one read port of the sorted store ram: one entry per cycle; samples are taken only in idle
// sync active-low reset clears control, batch count and sets the batch size r_cfg to 16
// sorted store contents are not cleared; only written entries are ever read
`default_nettype none

`include "even_count_median_filter_macros.svh"

module even_count_median_filter #(
    parameter int MAX_SAMPLES = ecmf_pkg::MAX_SAMPLES_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [ecmf_pkg::CFG_W-1:0]  i_cfg_wdata,
    ecmf_smp_if.sink                         i_smp,
    ecmf_res_if.source                       o_res
);

    import ecmf_pkg::*;

    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int CW = $clog2(MAX_SAMPLES + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCAN  = 7'b0000010,
        S_PLACE = 7'b0000100,
        S_CHECK = 7'b0001000,
        S_LO    = 7'b0010000,
        S_HI    = 7'b0100000,
        S_EMIT  = 7'b1000000
    } t_state;

    t_state                      r_state, n_state;
    logic [CFG_W-1:0]            r_cfg;
    logic [CW-1:0]               r_taken, n_taken;
    logic [AW-1:0]               r_pos, n_pos;
    logic signed [SAMPLE_W-1:0]  r_s, n_s;
    logic [SAMPLE_W-1:0]         r_lo, n_lo;
    logic signed [SAMPLE_W-1:0]  r_res_med, n_res_med;
    t_status                     r_res_st, n_res_st;
    logic                        r_out_valid, n_out_valid;
    logic signed [SAMPLE_W-1:0]  r_out_med, n_out_med;
    t_status                     r_out_st, n_out_st;

    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [SAMPLE_W-1:0]         ram_wdata;
    logic                        ram_re;
    logic [AW-1:0]               ram_raddr;
    logic [SAMPLE_W-1:0]         ram_rdata;

    logic                        smp_acc;
    logic                        out_take;
    logic                        cnt_ok;
    logic                        taken_full;
    logic [CFG_W-1:0]            half;
    logic [8:0]                  taken9;
    logic signed [SAMPLE_W:0]    mid_sum;
    logic signed [SAMPLE_W:0]    mid_adj;

    // sorted sample store
    ecmf_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_SAMPLES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // handshake
    assign smp_acc     = i_smp.valid && (r_state == S_IDLE);
    assign out_take    = r_out_valid && o_res.ready;
    assign i_smp.ready = (r_state == S_IDLE);
    assign o_res.valid  = r_out_valid;
    assign o_res.median = r_out_med;
    assign o_res.status = r_out_st;

    // batch size checks
    assign cnt_ok     = (r_cfg >= 8'd2) && !r_cfg[0] && ({1'b0, r_cfg} <= 9'(MAX_SAMPLES));
    assign taken_full = (r_taken >= CW'(MAX_SAMPLES));
    assign half       = {1'b0, r_cfg[CFG_W-1:1]};
    assign taken9     = 9'(r_taken);

    // mean of the two middle entries, rounded toward zero
    assign mid_sum = $signed({r_lo[SAMPLE_W-1], r_lo})
                   + $signed({ram_rdata[SAMPLE_W-1], ram_rdata});
    assign mid_adj = mid_sum + $signed({{SAMPLE_W{1'b0}}, mid_sum[SAMPLE_W]});

    // insertion sequencer
    always_comb begin
        n_state     = r_state;
        n_taken     = r_taken;
        n_pos       = r_pos;
        n_s         = r_s;
        n_lo        = r_lo;
        n_res_med   = r_res_med;
        n_res_st    = r_res_st;
        n_out_valid = r_out_valid && !out_take;
        n_out_med   = r_out_med;
        n_out_st    = r_out_st;
        ram_we      = 1'b0;
        ram_waddr   = r_pos;
        ram_wdata   = r_s;
        ram_re      = 1'b0;
        ram_raddr   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (smp_acc) begin
                    priority if (!cnt_ok) begin
                        n_taken   = '0;
                        n_res_med = '0;
                        n_res_st  = ST_BAD_COUNT;
                        n_state   = S_EMIT;
                    end else if (i_smp.timed_out) begin
                        n_taken   = '0;
                        n_res_med = '0;
                        n_res_st  = ST_TIMEOUT;
                        n_state   = S_EMIT;
                    end else if (taken_full) begin
                        n_state = S_CHECK;
                    end else begin
                        n_s   = i_smp.sample;
                        n_pos = AW'(r_taken);
                        if (r_taken == '0) begin
                            n_state = S_PLACE;
                        end else begin
                            ram_re    = 1'b1;
                            ram_raddr = AW'(r_taken - 1'b1);
                            n_state   = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN: begin
                ram_we    = 1'b1;
                ram_waddr = r_pos;
                if ($signed(ram_rdata) > r_s) begin
                    // shift the larger entry up one place
                    ram_wdata = ram_rdata;
                    n_pos     = r_pos - 1'b1;
                    if (r_pos == AW'(1)) begin
                        n_state = S_PLACE;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = r_pos - AW'(2);
                    end
                end else begin
                    ram_wdata = r_s;
                    n_taken   = r_taken + 1'b1;
                    n_state   = S_CHECK;
                end
            end
            S_PLACE: begin
                ram_we    = 1'b1;
                ram_waddr = r_pos;
                ram_wdata = r_s;
                n_taken   = r_taken + 1'b1;
                n_state   = S_CHECK;
            end
            S_CHECK: begin
                if (taken9 >= {1'b0, r_cfg}) begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(half - 8'd1);
                    n_state   = S_LO;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_LO: begin
                n_lo      = ram_rdata;
                ram_re    = 1'b1;
                ram_raddr = AW'(half);
                n_state   = S_HI;
            end
            S_HI: begin
                n_res_med = mid_adj[SAMPLE_W:1];
                n_res_st  = ST_OK;
                n_taken   = '0;
                n_state   = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_out_med   = r_res_med;
                    n_out_st    = r_res_st;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_taken     <= '0;
            r_out_valid <= 1'b0;
            r_cfg       <= CFG_RESET;
        end else begin
            r_state     <= n_state;
            r_taken     <= n_taken;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pos     <= n_pos;
        r_s       <= n_s;
        r_lo      <= n_lo;
        r_res_med <= n_res_med;
        r_res_st  <= n_res_st;
        r_out_med <= n_out_med;
        r_out_st  <= n_out_st;
    end

    // checks
    `ECMF_ASSERT_NOW(a_no_rw_clash, i_clk, i_rst_n, ram_we && ram_re, ram_waddr != ram_raddr)
    `ECMF_ASSERT_NOW(a_scan_pos, i_clk, i_rst_n, r_state == S_SCAN, r_pos != '0)
    `ECMF_ASSERT_NOW(a_batch_bound, i_clk, i_rst_n, r_state == S_IDLE,
        r_taken < CW'(MAX_SAMPLES))
    `ECMF_ASSERT_NEXT(a_emit_loads, i_clk, i_rst_n, (r_state == S_EMIT) && !r_out_valid,
        r_out_valid && (r_state == S_IDLE))

endmodule

`default_nettype wire

>>> rtl/core/ecmf_ram.sv
// generic single-clock ram, one write port, one registered read port
`default_nettype none

module ecmf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire logic [WIDTH-1:0]           i_wdata,
    input  wire logic                       i_re,
    input  wire logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic      [WIDTH-1:0]           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire
